// File: hdl/bap_pkg.sv
// Shared types and constants of the block average pixelation core.
// Used by bap_position, bap_sum_ram and block_average_pixelation_core; no dependencies.
package bap_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SUM_W     = 20;
  localparam int unsigned BLK_IDX_W = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 11;
  localparam int unsigned LOG2_W    = 3;
  localparam int unsigned SHIFT_W   = 4;
  localparam int unsigned OUT_DAT_W = 32;

  localparam logic [LOG2_W-1:0] LOG2_MAX = 3'd6;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2   = 2'd2;

  localparam logic [CFG_DAT_W-1:0] RST_IMAGE_WIDTH  = 11'd256;
  localparam logic [CFG_DAT_W-1:0] RST_IMAGE_HEIGHT = 11'd256;
  localparam logic [LOG2_W-1:0]    RST_BLOCK_LOG2   = 3'd5;

  typedef struct packed {
    logic                 first;
    logic                 last;
    logic                 done;
    logic [SHIFT_W-1:0]   shift;
    logic [BLK_IDX_W-1:0] brow;
    logic [BLK_IDX_W-1:0] bcol;
  } pos_info_t;

endpackage

// File: hdl/bap_sum_ram.sv
// Column sum memory: one write port, one read port with registered read data.
// Depends on bap_pkg for the sum width.
module bap_sum_ram
  import bap_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [SUM_W-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [SUM_W-1:0] wdata_i
);

  logic [SUM_W-1:0] mem_q [DEPTH];
  logic [SUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bap_position.sv
// Raster position counters and block decode for the pixelation core.
// Depends on bap_pkg for the position info struct and configuration limits.
module bap_position
  import bap_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned CW         = 10,
  parameter int unsigned RW         = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic [CFG_DAT_W-1:0] width_i,
  input  logic [CFG_DAT_W-1:0] height_i,
  input  logic [LOG2_W-1:0]    log2_i,
  output logic [CW-1:0]        addr_o,
  output pos_info_t            info_o
);

  logic [CW-1:0] col_q, col_d, col_eff, bcol;
  logic [RW-1:0] row_q, row_d, row_eff, brow;
  logic [31:0]   w32, h32, mask32, col_lo, row_lo, nbw, nbh, col_inc, row_inc;
  logic [LOG2_W-1:0] lg;
  logic          wrap;

  always_comb begin
    if (width_i == '0) begin
      w32 = 32'd1;
    end else if (32'(width_i) > MAX_WIDTH) begin
      w32 = MAX_WIDTH;
    end else begin
      w32 = 32'(width_i);
    end
    if (height_i == '0) begin
      h32 = 32'd1;
    end else if (32'(height_i) > MAX_HEIGHT) begin
      h32 = MAX_HEIGHT;
    end else begin
      h32 = 32'(height_i);
    end
    lg = (log2_i > LOG2_MAX) ? LOG2_MAX : log2_i;

    wrap    = (32'(col_q) >= w32) || (32'(row_q) >= h32);
    col_eff = wrap ? '0 : col_q;
    row_eff = wrap ? '0 : row_q;

    mask32 = (32'd1 << lg) - 32'd1;
    col_lo = 32'(col_eff) & mask32;
    row_lo = 32'(row_eff) & mask32;
    bcol   = col_eff >> lg;
    brow   = row_eff >> lg;
    nbw    = w32 >> lg;
    nbh    = h32 >> lg;

    info_o.first = (col_lo == 32'd0) && (row_lo == 32'd0);
    info_o.last  = (col_lo == mask32) && (row_lo == mask32);
    info_o.done  = (nbw != 32'd0) && (nbh != 32'd0) &&
                   (32'(bcol) == nbw - 32'd1) && (32'(brow) == nbh - 32'd1);
    info_o.shift = {lg, 1'b0};
    info_o.brow  = BLK_IDX_W'(brow);
    info_o.bcol  = BLK_IDX_W'(bcol);
    addr_o       = bcol;

    col_inc = 32'(col_eff) + 32'd1;
    row_inc = 32'(row_eff) + 32'd1;
    if (col_inc >= w32) begin
      col_d = '0;
      row_d = (row_inc >= h32) ? '0 : RW'(row_inc);
    end else begin
      col_d = CW'(col_inc);
      row_d = row_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (advance_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// File: hdl/block_average_pixelation_core.sv
// Block average pixelation core: streams raster pixels in, block means out.
// Depends on bap_pkg, bap_position and bap_sum_ram.
//
// Usage: pixels enter one per beat on the s_axis group (tdata[7:0] = pixel)
// in raster order. Each beat does one read-modify-write of the column sum
// memory, which holds one running sum per block column. On the bottom right
// pixel of a block a beat leaves on the m_axis group with the truncated mean,
// the block row and column, and tlast set on the last block of the frame.
// Throughput is one pixel per cycle while no result waits on a stalled
// m_axis, set by the single sum memory port pair; a write that collides
// with the following read is forwarded. The configuration channel takes
// image width, height and log2 of the block side at any time; write it
// only between frames while the core is idle. Reset restores 256 x 256
// with 32 pixel blocks and clears the position; the sum memory needs no
// clearing since each block writes before reading. When the receiver
// stalls with a result waiting, the core keeps accepting pixels until the
// next result would need the output register.
module block_average_pixelation_core
  import bap_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DAT_W-1:0]  m_axis_tdata,   // [7:0] block_mean, [17:8] block_row,
                                                // [27:18] block_col, [31:28] zero
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [CFG_DAT_W-1:0] width_q, height_q;
  logic [LOG2_W-1:0]    log2_q;

  logic          accept;
  logic [CW-1:0] addr;
  pos_info_t     info;

  logic             s1_valid_q, s1_fwd_q, s1_fwd_d, s1_go;
  pos_info_t        s1_info_q;
  logic [CW-1:0]    s1_addr_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [SUM_W-1:0] s1_fwd_data_q, rd_data, base, s1_sum, mean_full;

  logic                 out_valid_q, out_valid_d, out_done_q;
  logic [PIX_W-1:0]     out_mean_q;
  logic [BLK_IDX_W-1:0] out_row_q, out_col_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
      log2_q   <= RST_BLOCK_LOG2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        CFG_BLOCK_LOG2:   log2_q   <= cfg_data_i[LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  assign s1_go         = !s1_info_q.last || !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_go;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bap_position #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW)
  ) u_position (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (accept),
    .width_i   (width_q),
    .height_i  (height_q),
    .log2_i    (log2_q),
    .addr_o    (addr),
    .info_o    (info)
  );

  bap_sum_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .re_i    (accept),
    .raddr_i (addr),
    .rdata_o (rd_data),
    .we_i    (s1_valid_q && s1_go),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_sum)
  );

  always_comb begin
    base      = s1_fwd_q ? s1_fwd_data_q : rd_data;
    s1_sum    = s1_info_q.first ? SUM_W'(s1_pix_q) : base + SUM_W'(s1_pix_q);
    mean_full = s1_sum >> s1_info_q.shift;
    s1_fwd_d  = s1_valid_q && s1_go && (s1_addr_q == addr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q     <= info;
      s1_addr_q     <= addr;
      s1_pix_q      <= s_axis_tdata;
      s1_fwd_q      <= s1_fwd_d;
      s1_fwd_data_q <= s1_sum;
    end
  end

  always_comb begin
    if (s1_valid_q && s1_go && s1_info_q.last) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_go && s1_info_q.last) begin
      out_mean_q <= mean_full[PIX_W-1:0];
      out_row_q  <= s1_info_q.brow;
      out_col_q  <= s1_info_q.bcol;
      out_done_q <= s1_info_q.done;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DAT_W - PIX_W - 2 * BLK_IDX_W)'(0), out_col_q, out_row_q,
                          out_mean_q};
  assign m_axis_tlast  = out_done_q;

endmodule
